// ----- src/bta_pkg.sv -----
package bta_pkg;

    // Heap geometry.
    localparam int HEAP_BYTES = 65536;
    localparam int HDR_BYTES  = 16;
    localparam int FTR_BYTES  = 16;
    localparam int GRANULES   = HEAP_BYTES / 16;
    localparam int IDX_W      = $clog2(GRANULES);
    localparam int ADDR_W     = IDX_W + 6;
    localparam int SIZE_W     = 16;
    localparam int CNT_W      = IDX_W + 1;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    // Operation codes.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic              valid;
        logic              left;
        logic              used;
        logic [SIZE_W-1:0] size;
    } hdr_tag_t;

    typedef struct packed {
        logic              valid;
        logic              right;
        logic [SIZE_W-1:0] size;
    } ftr_tag_t;

    localparam int HDR_W = $bits(hdr_tag_t);
    localparam int FTR_W = $bits(ftr_tag_t);

    // Port of one tag memory as driven by the sequencer.
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] widx;
        logic [IDX_W-1:0] ridx;
    } mem_ctl_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] offset;
    } result_t;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE,
        S_A_HDR, S_A_FTR, S_A_SF, S_A_SP2,
        S_F_HDR, S_F_LF, S_F_LH, S_F_RF, S_F_FT, S_F_RH, S_F_RDF, S_F_FIN,
        S_DONE
    } state_t;

endpackage

// ----- src/boundary_tag_first_fit_allocator_core.sv -----
// Boundary-tag first-fit heap allocator over a 64 KiB heap with header and
// footer tags kept in two 4096-entry tag memories, one entry per 16-byte
// granule. After reset the core runs a clearing pass over both memories and
// holds s_tready low; then one free block spans the heap. The core takes one
// request at a time. An allocate walks the block chain, reading each visited
// header and the footer of each block that does not fit, then marks the first
// fit used and splits off the remainder if it is large enough. A free clears
// the used mark and merges the block with free neighbors on either side.
// Each request gives exactly one result; the result register lets a new request
// be taken while the previous result still waits on m_tready.
module boundary_tag_first_fit_allocator_core
    import bta_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operation [0], request_length [17:1], block_offset [33:18], zero fill
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status [1:0], result_offset [17:2], zero fill
    output logic [23:0] m_tdata
);

    mem_ctl_t hctl, fctl;
    hdr_tag_t hwdata, hrdata;
    ftr_tag_t fwdata, frdata;
    result_t  res;
    logic     res_load, out_free;
    logic     m_tvalid_reg, m_tvalid_next;
    result_t  m_res_reg, m_res_next;

    assign out_free = !m_tvalid_reg || m_tready;

    bta_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req_op    (s_tdata[0]),
        .req_len   (s_tdata[17:1]),
        .req_off   (s_tdata[33:18]),
        .out_free  (out_free),
        .res_load  (res_load),
        .res       (res),
        .hctl      (hctl),
        .hwdata    (hwdata),
        .hrdata    (hrdata),
        .fctl      (fctl),
        .fwdata    (fwdata),
        .frdata    (frdata)
    );

    bta_ram #(.WIDTH(HDR_W), .DEPTH(GRANULES)) u_hdr_ram (
        .aclk  (aclk),
        .we    (hctl.we),
        .waddr (hctl.widx),
        .wdata (hwdata),
        .raddr (hctl.ridx),
        .rdata (hrdata)
    );

    bta_ram #(.WIDTH(FTR_W), .DEPTH(GRANULES)) u_ftr_ram (
        .aclk  (aclk),
        .we    (fctl.we),
        .waddr (fctl.widx),
        .wdata (fwdata),
        .raddr (fctl.ridx),
        .rdata (frdata)
    );

    // Result register toward the master side.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_res_next    = m_res_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (res_load) begin
            m_tvalid_next = 1'b1;
            m_res_next    = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, m_res_reg.offset, m_res_reg.status};

endmodule

// ----- src/bta_ram.sv -----
module bta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/bta_seq.sv -----
module bta_seq
    import bta_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              req_valid,
    output logic              req_ready,
    input  logic              req_op,
    input  logic [16:0]       req_len,
    input  logic [15:0]       req_off,
    input  logic              out_free,
    output logic              res_load,
    output result_t           res,
    output mem_ctl_t          hctl,
    output hdr_tag_t          hwdata,
    input  hdr_tag_t          hrdata,
    output mem_ctl_t          fctl,
    output ftr_tag_t          fwdata,
    input  ftr_tag_t          frdata
);

    localparam logic [ADDR_W-1:0] HEAP_A = ADDR_W'(HEAP_BYTES);
    localparam logic [ADDR_W-1:0] HDR_A  = ADDR_W'(HDR_BYTES);
    localparam logic [ADDR_W-1:0] FTR_A  = ADDR_W'(FTR_BYTES);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ADDR_W-1:0] len_reg, len_next;
    logic [ADDR_W-1:0] head_reg, head_next;
    logic [ADDR_W-1:0] foot_reg, foot_next;
    logic [ADDR_W-1:0] left_reg, left_next;
    logic [ADDR_W-1:0] right_reg, right_next;
    logic [ADDR_W-1:0] aux_reg, aux_next;
    hdr_tag_t          ht_reg, ht_next;
    ftr_tag_t          ft_reg, ft_next;
    result_t           res_reg, res_next;
    logic              hoob_reg, foob_reg;

    logic [ADDR_W-1:0] h_ra, f_ra, h_wa, f_wa, fsum, diff;
    logic              h_we, f_we;
    hdr_tag_t          hq;
    ftr_tag_t          fq;
    logic [ADDR_W-1:0] off_a;

    // Reads outside the heap see an empty tag.
    assign hq = hoob_reg ? '0 : hrdata;
    assign fq = foob_reg ? '0 : frdata;
    assign off_a = ADDR_W'(req_off);
    assign fsum = head_reg + HDR_A + ADDR_W'(hq.size);
    assign diff = right_reg - left_reg - HDR_A;

    // Tag memory control; writes outside the heap are dropped.
    always_comb begin
        hctl.we   = h_we && (h_wa < HEAP_A);
        hctl.widx = h_wa[IDX_W+3:4];
        hctl.ridx = h_ra[IDX_W+3:4];
        fctl.we   = f_we && (f_wa < HEAP_A);
        fctl.widx = f_wa[IDX_W+3:4];
        fctl.ridx = f_ra[IDX_W+3:4];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg   <= len_next;
        head_reg  <= head_next;
        foot_reg  <= foot_next;
        left_reg  <= left_next;
        right_reg <= right_next;
        aux_reg   <= aux_next;
        ht_reg    <= ht_next;
        ft_reg    <= ft_next;
        res_reg   <= res_next;
        hoob_reg  <= (h_ra >= HEAP_A);
        foob_reg  <= (f_ra >= HEAP_A);
    end

    // Sequencer: every step reads or writes at most one entry of each tag memory.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        len_next   = len_reg;
        head_next  = head_reg;
        foot_next  = foot_reg;
        left_next  = left_reg;
        right_next = right_reg;
        aux_next   = aux_reg;
        ht_next    = ht_reg;
        ft_next    = ft_reg;
        res_next   = res_reg;
        h_ra       = '0;
        f_ra       = '0;
        h_wa       = '0;
        f_wa       = '0;
        h_we       = 1'b0;
        f_we       = 1'b0;
        hwdata     = '0;
        fwdata     = '0;
        req_ready  = 1'b0;
        res_load   = 1'b0;
        unique case (state_reg)
            // Clearing pass: one entry of each store a cycle, initial block tags included.
            S_CLR: begin
                h_we = 1'b1;
                f_we = 1'b1;
                h_wa = ADDR_W'({cnt_reg[IDX_W-1:0], 4'b0});
                f_wa = ADDR_W'({cnt_reg[IDX_W-1:0], 4'b0});
                if (cnt_reg[IDX_W-1:0] == '0) begin
                    hwdata.valid = 1'b1;
                    hwdata.size  = SIZE_W'(HEAP_BYTES - HDR_BYTES - FTR_BYTES);
                end
                if (cnt_reg[IDX_W-1:0] == IDX_W'(GRANULES - 1)) begin
                    fwdata.valid = 1'b1;
                    fwdata.size  = SIZE_W'(HEAP_BYTES - HDR_BYTES - FTR_BYTES);
                    state_next   = S_IDLE;
                    cnt_next     = '0;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IDLE: begin
                req_ready = 1'b1;
                res_next  = '0;
                if (req_valid) begin
                    if (req_op == OP_FREE) begin
                        head_next = off_a - HDR_A;
                        h_ra      = off_a - HDR_A;
                        if (off_a < HDR_A || (off_a - HDR_A) >= HEAP_A ||
                            (off_a[3:0] - HDR_A[3:0]) != 4'd0) begin
                            res_next.status = ST_INVALID;
                            state_next      = S_DONE;
                        end else begin
                            state_next = S_F_HDR;
                        end
                    end else if (req_len == '0) begin
                        res_next.status = ST_NOSPACE;
                        state_next      = S_DONE;
                    end else begin
                        len_next   = (ADDR_W'(req_len) + ADDR_W'(15)) & ~ADDR_W'(15);
                        head_next  = '0;
                        cnt_next   = '0;
                        state_next = S_A_HDR;
                    end
                end
            end
            // First-fit walk: check one header.
            S_A_HDR: begin
                if (cnt_reg > CNT_W'(GRANULES) || !hq.valid) begin
                    res_next.status = ST_NOSPACE;
                    state_next      = S_DONE;
                end else if (!hq.used && ADDR_W'(hq.size) >= len_reg) begin
                    h_we        = 1'b1;
                    h_wa        = head_reg;
                    hwdata      = hq;
                    hwdata.used = 1'b1;
                    ht_next     = hwdata;
                    foot_next   = fsum;
                    res_next.offset = 16'(head_reg + HDR_A);
                    if (ADDR_W'(hq.size) >= len_reg + HDR_A + FTR_A + ADDR_W'(16)) begin
                        f_ra       = fsum;
                        aux_next   = ADDR_W'(hq.size) - len_reg - HDR_A - FTR_A;
                        state_next = S_A_SF;
                    end else begin
                        res_next.status = ST_OK;
                        state_next      = S_DONE;
                    end
                end else begin
                    f_ra       = fsum;
                    foot_next  = fsum;
                    state_next = S_A_FTR;
                end
            end
            // Follow the footer to the right neighbor.
            S_A_FTR: begin
                if (!fq.valid || !fq.right) begin
                    res_next.status = ST_NOSPACE;
                    state_next      = S_DONE;
                end else begin
                    head_next  = foot_reg + FTR_A;
                    h_ra       = foot_reg + FTR_A;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_A_HDR;
                end
            end
            // Split, first half: shrink the header, place the new footer.
            S_A_SF: begin
                ft_next      = fq;
                h_we         = 1'b1;
                h_wa         = head_reg;
                hwdata       = ht_reg;
                hwdata.size  = SIZE_W'(len_reg);
                f_we         = 1'b1;
                f_wa         = head_reg + HDR_A + len_reg;
                fwdata.valid = 1'b1;
                fwdata.right = 1'b1;
                fwdata.size  = SIZE_W'(len_reg);
                state_next   = S_A_SP2;
            end
            // Split, second half: the remainder becomes a free block.
            S_A_SP2: begin
                f_we         = 1'b1;
                f_wa         = foot_reg;
                fwdata       = ft_reg;
                fwdata.size  = SIZE_W'(aux_reg);
                h_we         = 1'b1;
                h_wa         = foot_reg - aux_reg - HDR_A;
                hwdata.valid = 1'b1;
                hwdata.left  = 1'b1;
                hwdata.size  = SIZE_W'(aux_reg);
                res_next.status = ST_OK;
                state_next   = S_DONE;
            end
            // Free: clear the used mark, look left.
            S_F_HDR: begin
                if (!hq.valid) begin
                    res_next.status = ST_INVALID;
                    state_next      = S_DONE;
                end else begin
                    h_we        = 1'b1;
                    h_wa        = head_reg;
                    hwdata      = hq;
                    hwdata.used = 1'b0;
                    foot_next   = fsum;
                    right_next  = fsum;
                    left_next   = head_reg;
                    if (hq.left && head_reg >= FTR_A) begin
                        f_ra       = head_reg - FTR_A;
                        state_next = S_F_LF;
                    end else begin
                        state_next = S_F_RF;
                    end
                end
            end
            S_F_LF: begin
                aux_next   = head_reg - FTR_A - ADDR_W'(fq.size) - HDR_A;
                h_ra       = head_reg - FTR_A - ADDR_W'(fq.size) - HDR_A;
                state_next = S_F_LH;
            end
            S_F_LH: begin
                if (!hq.used) begin
                    left_next = aux_reg;
                    f_we      = 1'b1;
                    f_wa      = head_reg - FTR_A;
                    h_we      = 1'b1;
                    h_wa      = head_reg;
                end
                state_next = S_F_RF;
            end
            S_F_RF: begin
                f_ra       = foot_reg;
                state_next = S_F_FT;
            end
            S_F_FT: begin
                if (fq.right) begin
                    h_ra       = foot_reg + FTR_A;
                    state_next = S_F_RH;
                end else begin
                    state_next = S_F_RDF;
                end
            end
            S_F_RH: begin
                if (!hq.used) begin
                    right_next = foot_reg + FTR_A + HDR_A + ADDR_W'(hq.size);
                    f_we       = 1'b1;
                    f_wa       = foot_reg;
                    h_we       = 1'b1;
                    h_wa       = foot_reg + FTR_A;
                end
                state_next = S_F_RDF;
            end
            S_F_RDF: begin
                h_ra       = left_reg;
                f_ra       = right_reg;
                state_next = S_F_FIN;
            end
            // Write the merged size into both outer tags.
            S_F_FIN: begin
                h_we        = 1'b1;
                h_wa        = left_reg;
                hwdata      = hq;
                hwdata.size = SIZE_W'(diff);
                f_we        = 1'b1;
                f_wa        = right_reg;
                fwdata      = fq;
                fwdata.size = SIZE_W'(diff);
                res_next.status = ST_OK;
                state_next  = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign res = res_reg;

endmodule

// ----- src/bta_chk.sv -----
module bta_chk
    import bta_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [39:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // The clearing pass keeps the request side closed right after reset.
    a_reset_closed: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("request accepted during clearing pass");

    // A pending result holds until taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Only defined status codes appear.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] != 2'd3)
        else $error("undefined status code");

    // A nonzero offset comes only with success and is granule aligned.
    a_offset_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[17:2] != 16'd0 |-> m_tdata[1:0] == ST_OK && m_tdata[5:2] == 4'd0)
        else $error("offset with failing status or misaligned");

endmodule

bind boundary_tag_first_fit_allocator_core bta_chk u_bta_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
